// ===== design/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue cell chain.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DATA_W = 32;
   localparam int MODE_W = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 2'd0,
      MODE_DEL_FRONT = 2'd1,
      MODE_INS_REAR  = 2'd2,
      MODE_DEL_REAR  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // shift and write strobes broadcast to every cell of the chain
   typedef struct packed {
      logic shift_in_front;
      logic shift_out_front;
      logic write_rear;
   } cell_ctrl_type;

endpackage

// ===== design/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell
// One storage slot of the deque. Takes its left neighbor on a front insert,
// its right neighbor on a front removal, or the new value on a rear insert
// when it is the first free slot.
// ----------------------------------------------------------------------------
module dq_cell #(
   parameter int CW    = 5,
   parameter int INDEX = 0
) (
   input  logic                            clock,
   input  dq_pkg::cell_ctrl_type           ctrl,
   input  logic [CW-1:0]                   count,
   input  logic [dq_pkg::DATA_W-1:0]       left_data,
   input  logic [dq_pkg::DATA_W-1:0]       right_data,
   input  logic [dq_pkg::DATA_W-1:0]       insert_value,
   output logic [dq_pkg::DATA_W-1:0]       data,
   output logic [dq_pkg::DATA_W-1:0]       rear_tap
);

   logic [dq_pkg::DATA_W-1:0] data_ff;
   logic [dq_pkg::DATA_W-1:0] data_in;
   logic                      free_slot;
   logic                      rear_slot;

   assign free_slot = (count == CW'(INDEX));
   assign rear_slot = (count == CW'(INDEX + 1));

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_in_front) begin
         data_in = left_data;
      end else if (ctrl.shift_out_front) begin
         data_in = right_data;
      end else if (ctrl.write_rear && free_slot) begin
         data_in = insert_value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign rear_tap = rear_slot ? data_ff : '0;

endmodule

// ===== design/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a row of shifting cells.
//
//   channel   dir   handshake            payload
//   req       in    req_valid/req_ready  req_mode, req_value
//   rsp       out   rsp_valid/rsp_ready  rsp_removed_value, rsp_status,
//                                        rsp_occupancy
//
// one beat per cycle while req_ready is high; each result appears in the
// cycle after its request beat. The front entry always sits in cell 0, the
// rear in cell count-1; an insert or front removal is one shift or one write
// reset clears the count and the output valid; cell contents stay as they are
// req_ready drops only while a result is held and rsp_ready is low
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dq_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [dq_pkg::DATA_W-1:0]    req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dq_pkg::DATA_W-1:0]    rsp_removed_value,
   output logic [dq_pkg::STATUS_W-1:0]         rsp_status,
   output logic [dq_pkg::OCC_W-1:0]            rsp_occupancy
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CW + dq_pkg::OCC_W;

   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [dq_pkg::DATA_W-1:0]     removed_ff;
   logic [dq_pkg::DATA_W-1:0]     removed_in;
   dq_pkg::status_type            status_ff;
   dq_pkg::status_type            status_in;
   logic [dq_pkg::OCC_W-1:0]      occ_ff;
   logic [dq_pkg::OCC_W-1:0]      occ_in;
   logic [XW-1:0]                 count_wide;

   logic                          accept;
   logic                          full;
   logic                          empty;
   dq_pkg::mode_type              mode;
   dq_pkg::cell_ctrl_type         ctrl;
   logic [dq_pkg::DATA_W-1:0]     rear_value;

   logic [dq_pkg::DATA_W-1:0]     cell_data [DEPTH];
   logic [dq_pkg::DATA_W-1:0]     rear_tap  [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign mode      = dq_pkg::mode_type'(req_mode);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   assign ctrl.shift_in_front  = accept && (mode == dq_pkg::MODE_INS_FRONT) && !full;
   assign ctrl.shift_out_front = accept && (mode == dq_pkg::MODE_DEL_FRONT) && !empty;
   assign ctrl.write_rear      = accept && (mode == dq_pkg::MODE_INS_REAR) && !full;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [dq_pkg::DATA_W-1:0] left_data;
      logic [dq_pkg::DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = req_value;
      end else begin : g_mid
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end

      dq_cell #(
         .CW    (CW),
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .count        (count_ff),
         .left_data    (left_data),
         .right_data   (right_data),
         .insert_value (req_value),
         .data         (cell_data[i]),
         .rear_tap     (rear_tap[i])
      );
   end

   // only the cell at count-1 drives a nonzero tap
   always_comb begin
      rear_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_value = rear_value | rear_tap[i];
      end
   end

   always_comb begin
      count_in     = count_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         removed_in   = '0;
         status_in    = dq_pkg::ST_OK;
         case (mode)
            dq_pkg::MODE_INS_FRONT, dq_pkg::MODE_INS_REAR: begin
               if (full) begin
                  status_in = dq_pkg::ST_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            dq_pkg::MODE_DEL_FRONT: begin
               if (empty) begin
                  status_in = dq_pkg::ST_EMPTY;
               end else begin
                  removed_in = cell_data[0];
                  count_in   = count_ff - CW'(1);
               end
            end
            dq_pkg::MODE_DEL_REAR: begin
               if (empty) begin
                  status_in = dq_pkg::ST_EMPTY;
               end else begin
                  removed_in = rear_value;
                  count_in   = count_ff - CW'(1);
               end
            end
            default: begin
               status_in = dq_pkg::ST_OK;
            end
         endcase
         occ_in = count_wide[dq_pkg::OCC_W-1:0];
      end
   end

   assign count_wide = XW'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      removed_ff <= removed_in;
      status_ff  <= status_in;
      occ_ff     <= occ_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_status        = status_ff;
   assign rsp_occupancy     = occ_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      accept && full && (mode == dq_pkg::MODE_INS_FRONT || mode == dq_pkg::MODE_INS_REAR)
      |=> $stable(count_ff) && status_ff == dq_pkg::ST_FULL)
      else $error("insert on full queue changed the count");

   a_front_read: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift_out_front |=> removed_ff == $past(cell_data[0]))
      else $error("front removal returned the wrong entry");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == dq_pkg::ST_EMPTY |-> removed_ff == '0)
      else $error("failed removal carries a nonzero value");
`endif

endmodule
